>>> rtl/core/calu_pkg.sv
package calu_pkg;

  localparam logic [4:0] OP_AND   = 5'd0;
  localparam logic [4:0] OP_OR    = 5'd1;
  localparam logic [4:0] OP_XOR   = 5'd2;
  localparam logic [4:0] OP_BIT   = 5'd3;
  localparam logic [4:0] OP_CPL   = 5'd4;
  localparam logic [4:0] OP_ADD   = 5'd5;
  localparam logic [4:0] OP_ADC   = 5'd6;
  localparam logic [4:0] OP_SUB   = 5'd7;
  localparam logic [4:0] OP_SBC   = 5'd8;
  localparam logic [4:0] OP_SWAP  = 5'd9;
  localparam logic [4:0] OP_SET   = 5'd10;
  localparam logic [4:0] OP_RL    = 5'd11;
  localparam logic [4:0] OP_RR    = 5'd12;
  localparam logic [4:0] OP_RES   = 5'd13;
  localparam logic [4:0] OP_SLA   = 5'd14;
  localparam logic [4:0] OP_SRA   = 5'd15;
  localparam logic [4:0] OP_SRL   = 5'd16;
  localparam logic [4:0] OP_RLC   = 5'd17;
  localparam logic [4:0] OP_RRC   = 5'd18;
  localparam logic [4:0] OP_SCF   = 5'd19;
  localparam logic [4:0] OP_CCF   = 5'd20;
  localparam logic [4:0] OP_DAA   = 5'd21;
  localparam logic [4:0] OP_ADD16 = 5'd22;
  localparam logic [4:0] OP_SPOFS = 5'd23;

  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam logic [1:0] RULE_CALC  = 2'd0;
  localparam logic [1:0] RULE_SET   = 2'd1;
  localparam logic [1:0] RULE_CLEAR = 2'd2;
  localparam logic [1:0] RULE_KEEP  = 2'd3;

  localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
  localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
  localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
  localparam logic [7:0] DAA_HI_ADJ   = 8'h60;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] operand_x;
    logic [15:0] operand_y;
    logic [3:0]  flags_in;
    logic [7:0]  flag_rule;
  } calu_req_t;

  typedef struct packed {
    logic        known;
    logic [15:0] value;
    logic [3:0]  flags;
  } calu_res_t;

endpackage

>>> rtl/core/calu_core.sv
module calu_core
  import calu_pkg::*;
(
  input  calu_req_t req,
  output calu_res_t res
);

  logic [7:0]  x;
  logic [7:0]  y;
  logic        cin;
  logic [8:0]  sum8;
  logic [4:0]  sum4;
  logic [8:0]  dif8;
  logic [4:0]  dif4;
  logic [16:0] sum16;
  logic [12:0] sum12;
  logic [8:0]  lowb_sum;
  logic [4:0]  lown_sum;
  logic [7:0]  bit_mask;
  logic [7:0]  daa_adj;
  logic        daa_carry;
  logic        daa_sub;
  logic        wide;
  logic [15:0] r;
  logic [3:0]  f;

  assign x   = req.operand_x[7:0];
  assign y   = req.operand_y[7:0];
  assign cin = req.flags_in[FLAG_C];

  always_comb begin
    logic use_cin;
    use_cin   = (req.kind == OP_ADC) || (req.kind == OP_SBC);
    sum8      = {1'b0, x} + {1'b0, y} + {8'd0, use_cin & cin};
    sum4      = {1'b0, x[3:0]} + {1'b0, y[3:0]} + {4'd0, use_cin & cin};
    dif8      = {1'b0, x} - {1'b0, y} - {8'd0, use_cin & cin};
    dif4      = {1'b0, x[3:0]} - {1'b0, y[3:0]} - {4'd0, use_cin & cin};
    sum16     = {1'b0, req.operand_x} + {1'b0, req.operand_y};
    sum12     = {1'b0, req.operand_x[11:0]} + {1'b0, req.operand_y[11:0]};
    lowb_sum  = {1'b0, x} + {1'b0, y};
    lown_sum  = {1'b0, x[3:0]} + {1'b0, y[3:0]};
    bit_mask  = 8'd1 << y[2:0];
    daa_sub   = req.flags_in[FLAG_N];
    daa_carry = req.flags_in[FLAG_C] || (!daa_sub && (x > DAA_HI_LIMIT));
    daa_adj   = 8'd0;
    if (req.flags_in[FLAG_H] || (!daa_sub && (x[3:0] > DAA_LO_LIMIT))) begin
      daa_adj = daa_adj | DAA_LO_ADJ;
    end
    if (daa_carry) begin
      daa_adj = daa_adj | DAA_HI_ADJ;
    end
  end

  always_comb begin
    r         = 16'd0;
    f         = 4'd0;
    wide      = 1'b0;
    res.known = 1'b1;
    case (req.kind)
      OP_AND, OP_BIT: r[7:0] = x & y;
      OP_OR:          r[7:0] = x | y;
      OP_XOR:         r[7:0] = x ^ y;
      OP_CPL:         r[7:0] = ~x;
      OP_ADD, OP_ADC: begin
        r[7:0]    = sum8[7:0];
        f[FLAG_H] = sum4[4];
        f[FLAG_C] = sum8[8];
      end
      OP_SUB, OP_SBC: begin
        r[7:0]    = dif8[7:0];
        f[FLAG_H] = dif4[4];
        f[FLAG_C] = dif8[8];
      end
      OP_SWAP: r[7:0] = {x[3:0], x[7:4]};
      OP_SET:  r[7:0] = x | bit_mask;
      OP_RES:  r[7:0] = x & ~bit_mask;
      OP_RL: begin
        r[7:0]    = {x[6:0], cin};
        f[FLAG_C] = x[7];
      end
      OP_RR: begin
        r[7:0]    = {cin, x[7:1]};
        f[FLAG_C] = x[0];
      end
      OP_SLA: begin
        r[7:0]    = {x[6:0], 1'b0};
        f[FLAG_C] = x[7];
      end
      OP_SRA: begin
        r[7:0]    = {x[7], x[7:1]};
        f[FLAG_C] = x[0];
      end
      OP_SRL: begin
        r[7:0]    = {1'b0, x[7:1]};
        f[FLAG_C] = x[0];
      end
      OP_RLC: begin
        r[7:0]    = {x[6:0], x[7]};
        f[FLAG_C] = x[7];
      end
      OP_RRC: begin
        r[7:0]    = {x[0], x[7:1]};
        f[FLAG_C] = x[0];
      end
      OP_SCF: r = 16'd0;
      OP_CCF: f[FLAG_C] = ~cin;
      OP_DAA: begin
        r[7:0]    = daa_sub ? (x - daa_adj) : (x + daa_adj);
        f[FLAG_C] = daa_carry;
        f[FLAG_N] = req.flags_in[FLAG_N];
      end
      OP_ADD16: begin
        wide      = 1'b1;
        r         = sum16[15:0];
        f[FLAG_H] = sum12[12];
        f[FLAG_C] = sum16[16];
      end
      OP_SPOFS: begin
        wide      = 1'b1;
        r         = sum16[15:0];
        f[FLAG_H] = lown_sum[4];
        f[FLAG_C] = lowb_sum[8];
      end
      default: res.known = 1'b0;
    endcase
    f[FLAG_Z] = wide ? (r == 16'd0) : (r[7:0] == 8'd0);
    res.value = r;
    res.flags = f;
  end

endmodule

>>> rtl/core/calu_flags.sv
module calu_flags
  import calu_pkg::*;
(
  input  calu_res_t  calc,
  input  logic [3:0] flags_in,
  input  logic [7:0] flag_rule,
  output logic [15:0] result,
  output logic [3:0]  flags_out
);

  always_comb begin
    if (!calc.known) begin
      result    = 16'd0;
      flags_out = flags_in;
    end else begin
      result = calc.value;
      for (int i = 0; i < 4; i++) begin
        case (flag_rule[2*i +: 2])
          RULE_CALC:  flags_out[i] = calc.flags[i];
          RULE_SET:   flags_out[i] = 1'b1;
          RULE_CLEAR: flags_out[i] = 1'b0;
          RULE_KEEP:  flags_out[i] = flags_in[i];
          default:    flags_out[i] = calc.flags[i];
        endcase
      end
    end
  end

endmodule

>>> rtl/core/cpu_alu_with_flag_rules.sv
// ALU with per-flag rules. One item is taken on any cycle with start high;
// busy never rises, so a new item may follow in every cycle. Each item gives
// one result, held first in the input register and then in the result
// register. The result shows on result and flags_out for exactly one cycle
// while done is high; the receiver cannot stall, so it must capture it in
// that cycle.
module cpu_alu_with_flag_rules
  import calu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  kind,
  input  logic [15:0] operand_x,
  input  logic [15:0] operand_y,
  input  logic [3:0]  flags_in,
  input  logic [7:0]  flag_rule,
  output logic        done,
  output logic [15:0] result,
  output logic [3:0]  flags_out
);

  logic        req_valid;
  calu_req_t   req;
  calu_res_t   calc;
  logic [15:0] result_next;
  logic [3:0]  flags_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      req_valid <= start;
      done      <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req.kind      <= kind;
      req.operand_x <= operand_x;
      req.operand_y <= operand_y;
      req.flags_in  <= flags_in;
      req.flag_rule <= flag_rule;
    end
    if (req_valid) begin
      result    <= result_next;
      flags_out <= flags_next;
    end
  end

  calu_core u_core (
    .req (req),
    .res (calc)
  );

  calu_flags u_flags (
    .calc      (calc),
    .flags_in  (req.flags_in),
    .flag_rule (req.flag_rule),
    .result    (result_next),
    .flags_out (flags_next)
  );

endmodule

>>> test/alu_flag_checker.sv
module alu_flag_checker
  import calu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [4:0]  kind,
  input  logic [15:0] operand_x,
  input  logic [15:0] operand_y,
  input  logic [3:0]  flags_in,
  input  logic [7:0]  flag_rule,
  input  logic        done,
  input  logic [15:0] result,
  input  logic [3:0]  flags_out,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] value;
    logic [3:0]  flags;
  } alu_out_t;

  alu_out_t alu_expect_q[$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic alu_out_t predict_alu(logic [4:0] op, logic [15:0] wx, logic [15:0] wy,
                                           logic [3:0] fin, logic [7:0] rule);
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  r8;
    logic [7:0]  adj;
    logic [8:0]  s9;
    logic [4:0]  s5;
    logic [12:0] s13;
    logic [16:0] s17;
    logic [15:0] r;
    logic [3:0]  f;
    logic        cin;
    logic        sub;
    logic        wide;
    logic [1:0]  code;
    alu_out_t    o;
    x = wx[7:0];
    y = wy[7:0];
    cin = fin[FLAG_C];
    f = 4'h0;
    r8 = 8'h00;
    r = 16'h0000;
    wide = 1'b0;
    if (op > OP_SPOFS) begin
      o.value = 16'h0000;
      o.flags = fin;
      return o;
    end
    case (op)
      OP_AND, OP_BIT: r8 = x & y;
      OP_OR:   r8 = x | y;
      OP_XOR:  r8 = x ^ y;
      OP_CPL:  r8 = ~x;
      OP_ADD, OP_ADC: begin
        s9 = {1'b0, x} + {1'b0, y} + ((op == OP_ADC) ? {8'h00, cin} : 9'h000);
        s5 = {1'b0, x[3:0]} + {1'b0, y[3:0]} + ((op == OP_ADC) ? {4'h0, cin} : 5'h00);
        r8 = s9[7:0];
        f[FLAG_H] = s5[4];
        f[FLAG_C] = s9[8];
      end
      OP_SUB: begin
        r8 = x - y;
        f[FLAG_H] = y[3:0] > x[3:0];
        f[FLAG_C] = y > x;
      end
      OP_SBC: begin
        r8 = x - y - {7'h00, cin};
        f[FLAG_H] = ({1'b0, y[3:0]} + {4'h0, cin}) > {1'b0, x[3:0]};
        f[FLAG_C] = ({1'b0, y} + {8'h00, cin}) > {1'b0, x};
      end
      OP_SWAP: r8 = {x[3:0], x[7:4]};
      OP_SET:  r8 = x | (8'h01 << y[2:0]);
      OP_RES:  r8 = x & ~(8'h01 << y[2:0]);
      OP_RL: begin
        r8 = {x[6:0], cin};
        f[FLAG_C] = x[7];
      end
      OP_RR: begin
        r8 = {cin, x[7:1]};
        f[FLAG_C] = x[0];
      end
      OP_SLA: begin
        r8 = {x[6:0], 1'b0};
        f[FLAG_C] = x[7];
      end
      OP_SRA: begin
        r8 = {x[7], x[7:1]};
        f[FLAG_C] = x[0];
      end
      OP_SRL: begin
        r8 = {1'b0, x[7:1]};
        f[FLAG_C] = x[0];
      end
      OP_RLC: begin
        r8 = {x[6:0], x[7]};
        f[FLAG_C] = x[7];
      end
      OP_RRC: begin
        r8 = {x[0], x[7:1]};
        f[FLAG_C] = x[0];
      end
      OP_SCF: r8 = 8'h00;
      OP_CCF: begin
        r8 = 8'h00;
        f[FLAG_C] = ~cin;
      end
      OP_DAA: begin
        sub = fin[FLAG_N];
        adj = 8'h00;
        if (fin[FLAG_H] || (!sub && x[3:0] > DAA_LO_LIMIT)) adj = adj | DAA_LO_ADJ;
        if (fin[FLAG_C] || (!sub && x > DAA_HI_LIMIT)) begin
          adj = adj | DAA_HI_ADJ;
          f[FLAG_C] = 1'b1;
        end
        r8 = sub ? (x - adj) : (x + adj);
        f[FLAG_N] = fin[FLAG_N];
      end
      OP_ADD16: begin
        wide = 1'b1;
        s17 = {1'b0, wx} + {1'b0, wy};
        s13 = {1'b0, wx[11:0]} + {1'b0, wy[11:0]};
        r = s17[15:0];
        f[FLAG_H] = s13[12];
        f[FLAG_C] = s17[16];
      end
      default: begin
        wide = 1'b1;
        r = wx + wy;
        s5 = {1'b0, wx[3:0]} + {1'b0, wy[3:0]};
        s9 = {1'b0, wx[7:0]} + {1'b0, wy[7:0]};
        f[FLAG_H] = s5[4];
        f[FLAG_C] = s9[8];
      end
    endcase
    if (!wide) r = {8'h00, r8};
    f[FLAG_Z] = (r == 16'h0000);
    for (int i = 0; i < 4; i++) begin
      code = rule[2*i +: 2];
      case (code)
        RULE_CALC:  o.flags[i] = f[i];
        RULE_SET:   o.flags[i] = 1'b1;
        RULE_CLEAR: o.flags[i] = 1'b0;
        default:    o.flags[i] = fin[i];
      endcase
    end
    o.value = r;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
    if (mismatches < 20)
      $display("%0t alu %s mismatch: expected %h, got %h", $realtime, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    alu_out_t want;
    if (!rst) begin
      if (start && !busy)
        alu_expect_q.push_back(predict_alu(kind, operand_x, operand_y, flags_in, flag_rule));
      if (done) begin
        if (alu_expect_q.size() == 0) begin
          report_mismatch("unexpected result", 16'h0000, result);
        end else begin
          want = alu_expect_q.pop_front();
          if (result !== want.value) report_mismatch("result", want.value, result);
          if (flags_out !== want.flags)
            report_mismatch("flags", {12'h000, want.flags}, {12'h000, flags_out});
        end
      end
    end
    pending = alu_expect_q.size();
  end

endmodule

>>> test/testbench.sv
module testbench
  import calu_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [4:0]  kind = 5'd0;
  logic [15:0] operand_x = 16'h0000;
  logic [15:0] operand_y = 16'h0000;
  logic [3:0]  flags_in = 4'h0;
  logic [7:0]  flag_rule = 8'h00;
  logic        busy;
  logic        done;
  logic [15:0] result;
  logic [3:0]  flags_out;
  int          mismatches;
  int          pending;
  bit          burst = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cpu_alu_with_flag_rules u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .kind      (kind),
    .operand_x (operand_x),
    .operand_y (operand_y),
    .flags_in  (flags_in),
    .flag_rule (flag_rule),
    .done      (done),
    .result    (result),
    .flags_out (flags_out)
  );

  alu_flag_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .operand_x  (operand_x),
    .operand_y  (operand_y),
    .flags_in   (flags_in),
    .flag_rule  (flag_rule),
    .done       (done),
    .result     (result),
    .flags_out  (flags_out),
    .mismatches (mismatches),
    .pending    (pending)
  );

  task automatic issue_op(logic [4:0] op, logic [15:0] x, logic [15:0] y,
                          logic [3:0] fin, logic [7:0] rule);
    int gap;
    if ($urandom_range(0, 63) == 0) burst = !burst;
    gap = burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind <= op;
    operand_x <= x;
    operand_y <= y;
    flags_in <= fin;
    flag_rule <= rule;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h00FF;
      3: return 16'(($urandom_range(0, 9) << 4) | $urandom_range(0, 9));
      4: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic issue_random_op();
    logic [4:0]  op;
    logic [15:0] x;
    logic [7:0]  rule;
    op = ($urandom_range(0, 99) < 94) ? 5'($urandom_range(0, 23)) : 5'($urandom_range(24, 31));
    x = pick_operand();
    // keep many daa inputs in bcd form
    if (op == OP_DAA && $urandom_range(0, 1) == 1)
      x = {x[15:8], 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    rule = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    issue_op(op, x, pick_operand(), 4'($urandom_range(0, 15)), rule);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue_op(OP_AND,   16'h00FF, 16'h0000, 4'h0, 8'h00);
    issue_op(OP_OR,    16'hFFFF, 16'hFFFF, 4'hF, 8'h00);
    issue_op(OP_XOR,   16'h00AA, 16'h00AA, 4'h0, 8'h00);
    issue_op(OP_BIT,   16'h0080, 16'h0080, 4'h1, 8'h27);
    issue_op(OP_CPL,   16'hFF00, 16'h0000, 4'h0, 8'hD5);
    issue_op(OP_ADD,   16'h00FF, 16'h0001, 4'h0, 8'h00);
    issue_op(OP_ADC,   16'h000F, 16'h00F0, 4'h1, 8'h00);
    issue_op(OP_SUB,   16'h0000, 16'h0001, 4'h0, 8'h10);
    issue_op(OP_SBC,   16'h0010, 16'h000F, 4'h1, 8'h10);
    issue_op(OP_SWAP,  16'hFFF0, 16'h0000, 4'h0, 8'h00);
    issue_op(OP_SET,   16'h0000, 16'hFFFF, 4'h0, 8'hFF);
    issue_op(OP_RES,   16'h00FF, 16'h000B, 4'hF, 8'hFF);
    issue_op(OP_RL,    16'h0080, 16'h0000, 4'h1, 8'h00);
    issue_op(OP_RR,    16'h0001, 16'h0000, 4'h0, 8'h00);
    issue_op(OP_SLA,   16'h0080, 16'h0000, 4'h0, 8'h00);
    issue_op(OP_SRA,   16'h0081, 16'h0000, 4'h0, 8'h00);
    issue_op(OP_SRL,   16'h0001, 16'h0000, 4'h0, 8'h00);
    issue_op(OP_RLC,   16'h0080, 16'h0000, 4'h0, 8'h00);
    issue_op(OP_RRC,   16'h0001, 16'h0000, 4'h0, 8'h00);
    issue_op(OP_SCF,   16'h1234, 16'h5678, 4'h6, 8'hE9);
    issue_op(OP_CCF,   16'h0000, 16'h0000, 4'hF, 8'hE8);
    issue_op(OP_DAA,   16'h009A, 16'h0000, 4'h0, 8'h00);
    issue_op(OP_DAA,   16'h0000, 16'h0000, 4'h7, 8'h00);
    issue_op(OP_ADD16, 16'hFFFF, 16'h0001, 4'h0, 8'h00);
    issue_op(OP_SPOFS, 16'hFFFF, 16'hFFFF, 4'hF, 8'h00);
    issue_op(5'd24,    16'hFFFF, 16'hFFFF, 4'hA, 8'hFF);
    issue_op(5'd31,    16'h0000, 16'h0000, 4'h5, 8'h00);

    repeat (1650) issue_random_op();
    start <= 1'b0;

    wait (pending == 0);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
